>>> rtl/lrukv_pkg.sv
// Shared types, constants and control structures for the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

    // Table geometry and field widths
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;

    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [IDX_W-1:0]             age_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [CAP_W-1:0]             cap_t;
    typedef logic signed [KEY_BITS-1:0]   key_t;
    typedef logic signed [VALUE_BITS-1:0] val_t;

    // Request operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Capacity after reset and the value returned by a missing get
    localparam cap_t CAP_RESET = cap_t'(16);
    localparam val_t VAL_MISS  = '1;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/lrukv_ctrl.sv
// Request sequencer: alternates between taking a request and executing it.
`default_nettype none

module lrukv_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire lrukv_pkg::dp_status_t  status,
    output lrukv_pkg::ctrl_cmd_t        cmd
);

    lrukv_pkg::state_t state_reg;
    lrukv_pkg::state_t state_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrukv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: hold in execute until the result register can take the answer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrukv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lrukv_pkg::ST_EXEC;
                end
            end
            lrukv_pkg::ST_EXEC: begin
                if (status.out_free) begin
                    state_next = lrukv_pkg::ST_IDLE;
                end
            end
            default: state_next = lrukv_pkg::ST_IDLE;
        endcase
    end

    // Outputs: accept in idle, update the table once the result slot is free
    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            lrukv_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lrukv_pkg::ST_EXEC: begin
                cmd.exec = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lrukv_dp.sv
// Cache datapath: entry table, parallel key match, recency ages and result register.
`default_nettype none

module lrukv_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire lrukv_pkg::cap_t        cfg_wr_data,
    input  wire logic                   s_cmd,
    input  wire lrukv_pkg::key_t        s_key,
    input  wire lrukv_pkg::val_t        s_value,
    input  wire lrukv_pkg::ctrl_cmd_t   cmd,
    output lrukv_pkg::dp_status_t       status,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_hit,
    output lrukv_pkg::val_t             m_read_value
);

    localparam int N = lrukv_pkg::ENTRIES;

    // Configuration and request holding registers
    lrukv_pkg::cap_t cap_reg;
    logic            req_cmd_reg;
    lrukv_pkg::key_t req_key_reg;
    lrukv_pkg::val_t req_value_reg;

    // Entry table
    lrukv_pkg::key_t key_reg   [N];
    lrukv_pkg::val_t value_reg [N];
    lrukv_pkg::age_t age_reg   [N];
    lrukv_pkg::age_t age_next  [N];
    logic [N-1:0]    valid_reg;
    logic [N-1:0]    valid_next;
    lrukv_pkg::cnt_t occ_reg;
    lrukv_pkg::cnt_t occ_next;

    // Result register
    logic            m_valid_reg;
    logic            m_valid_next;
    logic            m_hit_reg;
    lrukv_pkg::val_t m_read_value_reg;

    // Lookup and replacement decode
    logic [N-1:0]    hit_vec;
    logic [N-1:0]    evict_vec;
    logic            found;
    lrukv_pkg::idx_t found_idx;
    lrukv_pkg::idx_t evict_idx;
    lrukv_pkg::idx_t free_idx;
    lrukv_pkg::idx_t ins_idx;
    lrukv_pkg::age_t hit_age;
    lrukv_pkg::val_t hit_value;
    lrukv_pkg::age_t oldest_age;
    lrukv_pkg::cnt_t eff_cap;
    logic            need_evict;
    logic            is_put;
    logic            wr_key;
    logic            wr_val;
    lrukv_pkg::idx_t wr_idx;
    logic            res_hit;
    lrukv_pkg::val_t res_value;

    assign is_put     = (req_cmd_reg == lrukv_pkg::CMD_PUT);
    assign oldest_age = lrukv_pkg::age_t'(occ_reg - 1'b1);

    // Compare every entry against the request key; mark the oldest valid entry
    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit_vec[i]   = valid_reg[i] && (key_reg[i] == req_key_reg);
            evict_vec[i] = valid_reg[i] && (age_reg[i] == oldest_age);
        end
    end

    // Encode the matching, oldest and lowest free slots
    always_comb begin
        found_idx = '0;
        evict_idx = '0;
        free_idx  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                found_idx = lrukv_pkg::idx_t'(i);
            end
            if (evict_vec[i]) begin
                evict_idx = lrukv_pkg::idx_t'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = lrukv_pkg::idx_t'(i);
            end
        end
    end

    assign found     = |hit_vec;
    assign hit_age   = age_reg[found_idx];
    assign hit_value = value_reg[found_idx];

    // Clamp capacity into one to the table size
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = lrukv_pkg::cnt_t'(1);
        end else if (int'(cap_reg) > N) begin
            eff_cap = lrukv_pkg::cnt_t'(N);
        end else begin
            eff_cap = lrukv_pkg::cnt_t'(cap_reg);
        end
    end

    assign need_evict = (occ_reg >= eff_cap) && (occ_reg != '0) && (|evict_vec);
    assign ins_idx    = need_evict ? evict_idx : free_idx;

    // Form the result for this request
    always_comb begin
        res_hit = found;
        if (found) begin
            res_value = is_put ? req_value_reg : hit_value;
        end else begin
            res_value = is_put ? req_value_reg : lrukv_pkg::VAL_MISS;
        end
    end

    // Table update: hit refreshes recency, put miss inserts with optional eviction
    always_comb begin
        valid_next   = valid_reg;
        occ_next     = occ_reg;
        age_next     = age_reg;
        wr_key       = 1'b0;
        wr_val       = 1'b0;
        wr_idx       = found_idx;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
            if (found) begin
                wr_val = is_put;
                for (int i = 0; i < N; i++) begin
                    if (valid_reg[i] && (lrukv_pkg::idx_t'(i) != found_idx)
                            && (age_reg[i] < hit_age)) begin
                        age_next[i] = lrukv_pkg::age_t'(age_reg[i] + 1'b1);
                    end
                end
                age_next[found_idx] = '0;
            end else if (is_put) begin
                wr_key = 1'b1;
                wr_val = 1'b1;
                wr_idx = ins_idx;
                for (int i = 0; i < N; i++) begin
                    if (valid_reg[i]
                            && !(need_evict && (lrukv_pkg::idx_t'(i) == ins_idx))) begin
                        age_next[i] = lrukv_pkg::age_t'(age_reg[i] + 1'b1);
                    end
                end
                age_next[ins_idx]   = '0;
                valid_next[ins_idx] = 1'b1;
                if (!need_evict) begin
                    occ_next = lrukv_pkg::cnt_t'(occ_reg + 1'b1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= lrukv_pkg::CAP_RESET;
            valid_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_cmd_reg   <= s_cmd;
            req_key_reg   <= s_key;
            req_value_reg <= s_value;
        end
    end

    // Entry payload and ages
    always_ff @(posedge aclk) begin
        age_reg <= age_next;
        if (wr_key) begin
            key_reg[wr_idx] <= req_key_reg;
        end
        if (wr_val) begin
            value_reg[wr_idx] <= req_value_reg;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_hit_reg        <= res_hit;
            m_read_value_reg <= res_value;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_read_value    = m_read_value_reg;

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= lrukv_pkg::cnt_t'(N))
        else $error("occupancy above table size");

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid bits");

    a_exec_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_valid_reg || m_ready))
        else $error("update while result register still full");

    a_load_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.exec)
        else $error("request load and update in the same cycle");

    a_put_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && !found && is_put) |=> valid_reg[$past(ins_idx)])
        else $error("inserted entry not marked valid");

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// A request is accepted in the idle state; in the execute state the controller matches
// and updates all entries and loads the result register, and no new request is taken
// until it returns to idle; a stalled result holds the update until the result
// register frees.
// Reset: synchronous, active low; clears valid bits, occupancy and the result
// register, and sets capacity to 16. No clearing pass is needed.
`default_nettype none

module lru_key_value_cache (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire lrukv_pkg::cap_t        cfg_wr_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire lrukv_pkg::key_t        s_key,
    input  wire lrukv_pkg::val_t        s_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_hit,
    output lrukv_pkg::val_t             m_read_value
);

    lrukv_pkg::ctrl_cmd_t  cmd;
    lrukv_pkg::dp_status_t status;

    // Sequence requests
    lrukv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the table and produce results
    lrukv_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_cmd        (s_cmd),
        .s_key        (s_key),
        .s_value      (s_value),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the LRU key-value cache: directed and random requests.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;

    // Track cache contents and recency; queue the result each request should give
    class lru_scoreboard;
        typedef struct packed {
            logic hit;
            lrukv_pkg::val_t read_value;
        } outcome_t;

        lrukv_pkg::key_t slot_key [lrukv_pkg::ENTRIES];
        lrukv_pkg::val_t slot_val [lrukv_pkg::ENTRIES];
        bit              slot_used [lrukv_pkg::ENTRIES];
        int unsigned     slot_age [lrukv_pkg::ENTRIES];
        int unsigned     used_count;
        lrukv_pkg::cap_t capacity;
        outcome_t        pending_q [$];
        int              failures;

        function new();
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            used_count = 0;
            capacity   = lrukv_pkg::CAP_RESET;
            failures   = 0;
        endfunction

        function void set_capacity(lrukv_pkg::cap_t c);
            capacity = c;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        // Apply one accepted request to the shadow table and queue its result
        function void note_request(logic cmd, lrukv_pkg::key_t key, lrukv_pkg::val_t value);
            int          found;
            int          slot;
            int          limit;
            int unsigned oldest;
            int unsigned cur_age;
            bit          any;
            outcome_t    res;
            found = -1;
            slot  = -1;
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                if (slot_used[i] && slot_key[i] == key) begin
                    found = i;
                    break;
                end
            end
            if (found >= 0) begin
                // hit: update on put, then make the entry most recent
                if (cmd == lrukv_pkg::CMD_PUT) slot_val[found] = value;
                cur_age = slot_age[found];
                for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
                    if (slot_used[i] && i != found && slot_age[i] < cur_age)
                        slot_age[i]++;
                slot_age[found] = 0;
                res.hit = 1'b1;
                res.read_value = slot_val[found];
            end else if (cmd == lrukv_pkg::CMD_GET) begin
                res.hit = 1'b0;
                res.read_value = lrukv_pkg::VAL_MISS;
            end else begin
                // clamp capacity to 1 .. ENTRIES
                limit = int'(capacity);
                if (limit < 1) limit = 1;
                if (limit > lrukv_pkg::ENTRIES) limit = lrukv_pkg::ENTRIES;
                // evict the least recent entry once the table is at capacity
                if (used_count >= limit && used_count > 0) begin
                    any = 1'b0;
                    oldest = 0;
                    for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                        if (slot_used[i] && (!any || slot_age[i] > oldest)) begin
                            oldest = slot_age[i];
                            slot = i;
                            any = 1'b1;
                        end
                    end
                    if (any) begin
                        slot_used[slot] = 1'b0;
                        used_count--;
                    end
                end
                // otherwise take the lowest free slot
                if (slot < 0) begin
                    for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                        if (!slot_used[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot >= 0) begin
                    for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
                        if (slot_used[i]) slot_age[i]++;
                    slot_key[slot]  = key;
                    slot_val[slot]  = value;
                    slot_used[slot] = 1'b1;
                    slot_age[slot]  = 0;
                    used_count++;
                end
                res.hit = 1'b0;
                res.read_value = value;
            end
            pending_q.push_back(res);
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_result(logic hit, lrukv_pkg::val_t read_value);
            outcome_t want;
            if (pending_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: hit %0b read_value %0d", hit, read_value);
                return;
            end
            want = pending_q.pop_front();
            if (hit !== want.hit || read_value !== want.read_value) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: hit exp %0b got %0b, read_value exp %0d got %0d",
                             want.hit, hit, want.read_value, read_value);
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    lrukv_pkg::cap_t cfg_wr_data;
    logic            s_valid;
    logic            s_ready;
    logic            s_cmd;
    lrukv_pkg::key_t s_key;
    lrukv_pkg::val_t s_value;
    logic            m_valid;
    logic            m_ready;
    logic            m_hit;
    lrukv_pkg::val_t m_read_value;

    lru_scoreboard   sb;
    lrukv_pkg::key_t key_pool [POOL_SIZE];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              stall_left    = 0;
    int              cycle_count   = 0;

    lru_key_value_cache uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_key_value_cache regression: fail");
            $finish;
        end
    end

    // Drive result ready: hold off for a counted stretch, else idle at random
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_hit, m_read_value);
    end

    // Offer one request, idling first at random, and record it once accepted
    task automatic send_request(logic cmd, lrukv_pkg::key_t key, lrukv_pkg::val_t value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, key, value);
    endtask

    // Mostly reuse keys from a window of the pool so hits and evictions occur
    task automatic random_request(int span);
        logic            cmd;
        lrukv_pkg::key_t key;
        lrukv_pkg::val_t value;
        cmd = logic'($urandom_range(1));
        if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(span - 1)];
        else
            key = lrukv_pkg::key_t'($urandom);
        value = lrukv_pkg::val_t'($urandom);
        send_request(cmd, key, value);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic finish_phase();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(lrukv_pkg::cap_t c);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(c);
    endtask

    initial begin
        lrukv_pkg::cap_t phase_caps [6];
        int              limit;
        int              span;
        sb = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_cmd       = lrukv_pkg::CMD_GET;
        s_key       = '0;
        s_value     = '0;
        m_ready     = 1'b0;
        phase_caps  = '{lrukv_pkg::cap_t'(4), lrukv_pkg::cap_t'(16), lrukv_pkg::cap_t'(1),
                        lrukv_pkg::cap_t'(9), lrukv_pkg::cap_t'(31), lrukv_pkg::cap_t'(2)};
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = lrukv_pkg::key_t'(32'h8000_0000);
        key_pool[3] = lrukv_pkg::key_t'(32'h7fff_ffff);
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = lrukv_pkg::key_t'($urandom);

        // hold reset, then release it
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, both operations, update and miss
        write_capacity(lrukv_pkg::cap_t'(16));
        send_request(lrukv_pkg::CMD_GET, '0, '0);
        send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(32'h8000_0000),
                     lrukv_pkg::val_t'(32'h7fff_ffff));
        send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(32'h7fff_ffff),
                     lrukv_pkg::val_t'(32'h8000_0000));
        send_request(lrukv_pkg::CMD_PUT, '0, '0);
        send_request(lrukv_pkg::CMD_PUT, '1, '1);
        send_request(lrukv_pkg::CMD_GET, lrukv_pkg::key_t'(32'h8000_0000), '0);
        send_request(lrukv_pkg::CMD_GET, '1, lrukv_pkg::val_t'(32'h5a5a_a5a5));
        send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(32'h7fff_ffff),
                     lrukv_pkg::val_t'(12345));
        send_request(lrukv_pkg::CMD_GET, lrukv_pkg::key_t'(12345), '0);
        finish_phase();

        // zero capacity acts as one, below the current occupancy
        write_capacity(lrukv_pkg::cap_t'(0));
        send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(7), lrukv_pkg::val_t'(70));
        send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(8), lrukv_pkg::val_t'(80));
        send_request(lrukv_pkg::CMD_GET, lrukv_pkg::key_t'(7), '0);
        finish_phase();

        // capacity above the table size: fill every slot, then evict once
        write_capacity(lrukv_pkg::cap_t'(31));
        for (int i = 0; i < 13; i++)
            send_request(lrukv_pkg::CMD_PUT, lrukv_pkg::key_t'(100 + i),
                         lrukv_pkg::val_t'(1000 + i));
        finish_phase();

        // random phases: sender idles lightly, then receiver lightly, then neither
        for (int blk = 0; blk < 6; blk++) begin
            case (blk / 2)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_capacity(phase_caps[blk]);
            limit = int'(phase_caps[blk]);
            if (limit < 1) limit = 1;
            if (limit > lrukv_pkg::ENTRIES) limit = lrukv_pkg::ENTRIES;
            span = (limit + 4 > POOL_SIZE) ? POOL_SIZE : limit + 4;

            // stall the result side for a long stretch while requests keep coming
            if (blk == 1) begin
                send_idle_pct = 0;
                stall_left = 240;
                repeat (10) random_request(span);
                finish_phase();
                send_idle_pct = 18;
            end

            repeat (320) random_request(span);
            finish_phase();
        end

        // allow any stray result to show up
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("lru_key_value_cache regression: pass");
        else
            $display("lru_key_value_cache regression: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/lrukv_pkg.sv
rtl/lrukv_ctrl.sv
rtl/lrukv_dp.sv
rtl/lru_key_value_cache.sv
sim/testbench.sv
